// ===== design/dsnr_pkg.sv =====
// Shared types and constants for the decimal sum number reader.
// Holds the transaction structs, scan phase codes and character codes.
// No dependencies.
package dsnr_pkg;

   localparam int COUNT_BITS_DEFAULT = 16;

   localparam int VALUE_BITS = 64;
   localparam int TIMES_BITS = 16;
   localparam int PHASE_BITS = 3;

   // scan phases
   localparam logic [PHASE_BITS-1:0] PH_SKIP    = 3'd0;
   localparam logic [PHASE_BITS-1:0] PH_COMMENT = 3'd1;
   localparam logic [PHASE_BITS-1:0] PH_SIGN    = 3'd2;
   localparam logic [PHASE_BITS-1:0] PH_PCT     = 3'd3;
   localparam logic [PHASE_BITS-1:0] PH_DIGITS  = 3'd4;
   localparam logic [PHASE_BITS-1:0] PH_COUNT   = 3'd5;

   // character codes
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;

   localparam logic [3:0] DECIMAL_BASE = 4'd10;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_data;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] value;
      logic [TIMES_BITS-1:0]        times;
      logic                         overflowed;
      logic                         closed_by_end;
   } rsp_type;

endpackage

// ===== design/decimal_sum_number_reader.sv =====
// Decimal sum number reader: top level, scanner and output buffering.
// Depends on dsnr_pkg for transaction types, phase codes and characters.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------------
//   req     | in        | req_valid/req_stall  | char_code, end_of_data
//   rsp     | out       | rsp_valid/rsp_stall  | value, times, overflowed, closed_by_end
//
// Flow: one character per clock while req_stall is low. A transaction that ends a
//   number gives its result on rsp in the cycle after acceptance when the head
//   entry is free or drains at that edge; otherwise it waits in the skid entry
//   behind the head. The path is one x10 add (shift-add) with range compare, or
//   one 64-bit add with overflow, between registers.
// Stalls: a two-entry output buffer (head plus skid) parts the sides; req_stall
//   rises only when both entries hold a result, so input keeps flowing while a
//   result waits.
// Reset: synchronous, active high; clears scan state, the last value and the
//   buffer valid bits. After end of data every transaction is taken and dropped.
module decimal_sum_number_reader #(
   parameter int COUNT_BITS = dsnr_pkg::COUNT_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dsnr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dsnr_pkg::rsp_type rsp_data
);
   import dsnr_pkg::*;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [VALUE_BITS-1:0] POS_LIMIT = {1'b0, {(VALUE_BITS-1){1'b1}}};
   localparam logic [VALUE_BITS-1:0] NEG_LIMIT = {1'b1, {(VALUE_BITS-1){1'b0}}};

   // scan state
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [VALUE_BITS-1:0] total_ff, total_in;
   logic [VALUE_BITS-1:0] term_ff, term_in;
   logic                  neg_ff, neg_in;
   logic [VALUE_BITS-1:0] prev_ff, prev_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  wrap_ff, wrap_in;
   logic                  ended_ff, ended_in;
   logic                  open_ff, open_in;

   // output buffer: head entry drives rsp, skid entry catches overflow
   rsp_type out_ff, out_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type skid_ff, skid_in;
   logic    skid_valid_ff, skid_valid_in;

   logic    accept;
   logic    pop;
   logic    push;
   rsp_type result;

   // datapath helpers
   logic [7:0]              ch;
   logic                    is_dig;
   logic                    is_sign;
   logic [3:0]              dig;
   logic [VALUE_BITS+3:0]   term_x10;
   logic [VALUE_BITS+3:0]   term_lim;
   logic                    term_ovf;
   logic [VALUE_BITS-1:0]   signed_term;
   logic [VALUE_BITS-1:0]   sum;
   logic                    sum_ovf;
   logic [COUNT_BITS+3:0]   count_x10;
   logic [COUNT_BITS-1:0]   count_next;
   logic [32:0]             count_wide;
   logic [TIMES_BITS-1:0]   count_times;

   // control flags for the step
   logic emit_now;
   logic emit_count;
   logic emit_end;
   logic do_scan;

   assign accept    = req_valid && !req_stall;
   assign req_stall = skid_valid_ff;
   assign pop       = out_valid_ff && !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   assign ch      = req_data.char_code;
   assign is_dig  = ch inside {[CH_ZERO:CH_NINE]};
   assign is_sign = ch inside {CH_PLUS, CH_MINUS};
   assign dig     = 4'(ch - CH_ZERO);

   // term * 10 + digit, exact, then compare against the signed range bound
   assign term_x10 = ({4'b0, term_ff} << 3) + ({4'b0, term_ff} << 1)
                     + (VALUE_BITS+4)'(dig);
   assign term_lim = {4'b0, (neg_ff ? NEG_LIMIT : POS_LIMIT)};
   assign term_ovf = term_x10 > term_lim;

   // close the current term into the running total
   assign signed_term = neg_ff ? (VALUE_BITS'(0) - term_ff) : term_ff;
   assign sum         = total_ff + signed_term;
   assign sum_ovf     = (~(total_ff[VALUE_BITS-1] ^ signed_term[VALUE_BITS-1]))
                        & (total_ff[VALUE_BITS-1] ^ sum[VALUE_BITS-1]);

   // repeat count * 10 + digit, saturating at the counter width
   assign count_x10  = ({4'b0, count_ff} << 3) + ({4'b0, count_ff} << 1)
                       + (COUNT_BITS+4)'(dig);
   assign count_next = (count_x10[COUNT_BITS+3:COUNT_BITS] != 4'd0) ? COUNT_MAX
                       : count_x10[COUNT_BITS-1:0];

   // times field: zero reads as one, clip at the field width
   assign count_wide  = 33'(count_ff);
   assign count_times = (count_wide == 33'd0) ? TIMES_BITS'(1)
                        : (count_wide > 33'(16'hFFFF)) ? {TIMES_BITS{1'b1}}
                        : count_wide[TIMES_BITS-1:0];

   always_comb begin
      phase_in   = phase_ff;
      total_in   = total_ff;
      term_in    = term_ff;
      neg_in     = neg_ff;
      prev_in    = prev_ff;
      count_in   = count_ff;
      wrap_in    = wrap_ff;
      ended_in   = ended_ff;
      open_in    = open_ff;
      emit_now   = 1'b0;
      emit_count = 1'b0;
      emit_end   = 1'b0;
      do_scan    = 1'b0;
      result     = '0;

      if (accept && !ended_ff) begin
         if (req_data.end_of_data) begin
            ended_in = 1'b1;
            emit_end = 1'b1;
            case (phase_ff)
               PH_DIGITS: begin
                  total_in = sum;
                  wrap_in  = wrap_ff | sum_ovf;
                  term_in  = '0;
                  neg_in   = 1'b0;
                  emit_now = 1'b1;
               end
               PH_COUNT: begin
                  emit_now   = 1'b1;
                  emit_count = 1'b1;
               end
               PH_PCT: begin
                  total_in = prev_ff;
                  wrap_in  = 1'b0;
                  emit_now = 1'b1;
               end
               default: begin
                  emit_now = open_ff;
               end
            endcase
         end else begin
            case (phase_ff)
               PH_COMMENT: begin
                  if (ch == CH_NEWLINE) begin
                     phase_in = PH_SKIP;
                  end
               end
               PH_SIGN: begin
                  if (is_dig) begin
                     if (!open_ff) begin
                        total_in = '0;
                        wrap_in  = 1'b0;
                        open_in  = 1'b1;
                     end
                     term_in  = VALUE_BITS'(dig);
                     phase_in = PH_DIGITS;
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end
               PH_PCT: begin
                  // load the last value as the start of the sum
                  total_in = prev_ff;
                  wrap_in  = 1'b0;
                  open_in  = 1'b1;
                  if (is_sign) begin
                     neg_in   = (ch == CH_MINUS);
                     term_in  = '0;
                     phase_in = PH_SIGN;
                  end else if (ch == CH_SLASH) begin
                     count_in = '0;
                     phase_in = PH_COUNT;
                  end else begin
                     emit_now = 1'b1;
                     do_scan  = 1'b1;
                  end
               end
               PH_DIGITS: begin
                  if (is_dig) begin
                     term_in = term_x10[VALUE_BITS-1:0];
                     wrap_in = wrap_ff | term_ovf;
                  end else begin
                     total_in = sum;
                     wrap_in  = wrap_ff | sum_ovf;
                     term_in  = '0;
                     neg_in   = 1'b0;
                     if (is_sign) begin
                        neg_in   = (ch == CH_MINUS);
                        phase_in = PH_SIGN;
                     end else if (ch == CH_SLASH) begin
                        count_in = '0;
                        phase_in = PH_COUNT;
                     end else begin
                        emit_now = 1'b1;
                        do_scan  = 1'b1;
                     end
                  end
               end
               PH_COUNT: begin
                  if (is_dig) begin
                     count_in = count_next;
                  end else begin
                     // the count terminator is consumed, not rescanned
                     emit_now   = 1'b1;
                     emit_count = 1'b1;
                  end
               end
               default: begin
                  do_scan = 1'b1;
               end
            endcase
         end

         if (emit_now) begin
            result.value         = total_in;
            result.times         = emit_count ? count_times : TIMES_BITS'(1);
            result.overflowed    = wrap_in;
            result.closed_by_end = emit_end;
            prev_in              = total_in;
            open_in              = 1'b0;
            phase_in             = PH_SKIP;
         end

         // rescan the character as garbage or as the start of a number
         if (do_scan) begin
            if (is_dig) begin
               if (!open_in) begin
                  total_in = '0;
                  wrap_in  = 1'b0;
                  open_in  = 1'b1;
               end
               term_in  = VALUE_BITS'(dig);
               neg_in   = 1'b0;
               phase_in = PH_DIGITS;
            end else if (ch == CH_PERCENT) begin
               if (open_in) begin
                  term_in  = '0;
                  neg_in   = 1'b0;
                  phase_in = PH_DIGITS;
               end else begin
                  phase_in = PH_PCT;
               end
            end else if (is_sign) begin
               neg_in   = (ch == CH_MINUS);
               term_in  = '0;
               phase_in = PH_SIGN;
            end else if (ch == CH_STAR) begin
               phase_in = PH_COMMENT;
            end else begin
               phase_in = PH_SKIP;
            end
         end
      end
   end

   assign push = emit_now;

   // output buffer: advance skid into head on pop, drop head when drained
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (pop) begin
         out_in       = result;
         out_valid_in = push;
      end else if (push) begin
         if (out_valid_ff) begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end else begin
            out_in       = result;
            out_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SKIP;
         total_ff      <= '0;
         term_ff       <= '0;
         neg_ff        <= 1'b0;
         prev_ff       <= '0;
         count_ff      <= '0;
         wrap_ff       <= 1'b0;
         ended_ff      <= 1'b0;
         open_ff       <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         total_ff      <= total_in;
         term_ff       <= term_in;
         neg_ff        <= neg_in;
         prev_ff       <= prev_in;
         count_ff      <= count_in;
         wrap_ff       <= wrap_in;
         ended_ff      <= ended_in;
         open_ff       <= open_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   a_skid_needs_head: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without a head entry");

   a_ended_sticky: assert property (@(posedge clock) disable iff (reset)
      ended_ff |=> ended_ff)
      else $error("end of data flag cleared");

   a_no_result_after_end: assert property (@(posedge clock) disable iff (reset)
      ended_ff |-> !push)
      else $error("result produced after end of data");

   a_number_phase_open: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DIGITS || phase_ff == PH_COUNT) |-> open_ff)
      else $error("digit or count phase without an open number");

endmodule
